// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the gate passage tracker port checker.
// Plain header, no dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held.
`define GPST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define GPST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gpst_pkg.sv =====
// Package for the gate passage sensor tracker: payload structs, state struct
// and the status, mode and mask codes. No dependencies.
`timescale 1ns / 1ps

package gpst_pkg;

    // status codes
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_BOTH       = 3'd1;
    localparam logic [2:0] ST_ALARM_EXIT = 3'd2;
    localparam logic [2:0] ST_ALARM_ENTR = 3'd3;
    localparam logic [2:0] ST_ALARM_MID  = 3'd4;
    localparam logic [2:0] ST_PASS_WAIT  = 3'd5;
    localparam logic [2:0] ST_PASS_OK    = 3'd6;

    // mode / task codes
    localparam logic [1:0] MD_IDLE  = 2'd0;
    localparam logic [1:0] MD_ENTR  = 2'd1;
    localparam logic [1:0] MD_EXIT  = 2'd2;
    localparam logic [1:0] MD_ALARM = 2'd3;

    // request types
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // beam masks
    localparam logic [3:0] FULL_MASK = 4'hF;
    localparam logic [3:0] OUT_ONLY  = 4'h8;
    localparam logic [3:0] IN_ONLY   = 4'h1;
    localparam logic [3:0] NO_BEAMS  = 4'h0;

    typedef struct packed {
        logic       req_type;
        logic [3:0] sensor_levels;
        logic [1:0] new_mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] mode_now;
    } t_out_item;

    typedef struct packed {
        logic [1:0] active_task;
        logic       entry_done;
        logic       pass_step;
        logic [3:0] seen_mask;
        logic [2:0] status;
        logic [1:0] mode;
    } t_state;

    localparam t_state STATE_RESET = '{
        active_task: MD_IDLE,
        entry_done:  1'b0,
        pass_step:   1'b0,
        seen_mask:   NO_BEAMS,
        status:      ST_NONE,
        mode:        MD_IDLE
    };

endpackage

// ===== hw/rtl/gpst_step.sv =====
// Next-state logic of the tracker for one transaction: set command, passage
// tracking (entrance/exit) and alarm classification. Uses gpst_pkg.
`timescale 1ns / 1ps

module gpst_step
    import gpst_pkg::*;
(
    input  t_state   i_state,
    input  t_in_item i_item,
    output t_state   o_state
);

    logic [3:0] beams;
    logic [3:0] wrong_first;
    logic [2:0] wrong_status;
    t_state     s;

    // beams are interrupted when their level is low
    assign beams = ~i_item.sensor_levels;

    // entrance guards against an out-only start, exit against an in-only start
    assign wrong_first  = (i_state.active_task == MD_ENTR) ? OUT_ONLY : IN_ONLY;
    assign wrong_status = (i_state.active_task == MD_ENTR) ? ST_ALARM_EXIT : ST_ALARM_ENTR;

    always_comb begin
        s = i_state;
        if (i_item.req_type == REQ_SET) begin
            // restart the selected mode
            s.mode        = i_item.new_mode;
            s.active_task = i_item.new_mode;
            s.entry_done  = 1'b0;
        end else begin
            unique case (i_state.active_task)
                MD_ENTR, MD_EXIT: begin
                    if (!s.entry_done) begin
                        s.entry_done = 1'b1;
                        s.pass_step  = 1'b0;
                        s.seen_mask  = NO_BEAMS;
                        s.status     = ST_PASS_WAIT;
                        s.mode       = i_state.active_task;
                    end
                    if (!s.pass_step) begin
                        // collect beams unless the wrong side came first
                        if (s.seen_mask == wrong_first) begin
                            s.status = wrong_status;
                        end else begin
                            s.seen_mask = s.seen_mask | beams;
                            s.status    = ST_PASS_WAIT;
                        end
                        if (s.seen_mask == FULL_MASK) begin
                            s.pass_step = 1'b1;
                        end
                    end else if (beams == NO_BEAMS) begin
                        // all clear: report and fall back to idle
                        s.status      = ST_PASS_OK;
                        s.active_task = MD_IDLE;
                        s.entry_done  = 1'b0;
                    end
                end
                MD_ALARM: begin
                    if (!s.entry_done) begin
                        s.entry_done = 1'b1;
                        s.pass_step  = 1'b0;
                        s.mode       = MD_ALARM;
                    end
                    // classify the beams interrupted right now
                    if (beams == NO_BEAMS) begin
                        s.status = ST_NONE;
                    end else if (beams[3] && beams[0]) begin
                        s.status = ST_BOTH;
                    end else if (beams[3]) begin
                        s.status = ST_ALARM_EXIT;
                    end else if (beams[0]) begin
                        s.status = ST_ALARM_ENTR;
                    end else begin
                        s.status = ST_ALARM_MID;
                    end
                end
                MD_IDLE: begin
                    if (!s.entry_done) begin
                        s.entry_done = 1'b1;
                        s.pass_step  = 1'b0;
                        s.mode       = MD_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_state = s;

endmodule

// ===== hw/rtl/gate_passage_sensor_tracker_core.sv =====
// Top level of the gate passage sensor tracker: input register, state
// register and result register around gpst_step. Uses gpst_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries sensor ticks
//   and set-mode commands. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns one result per input transaction: the status and the
//   reported mode after that transaction.
//   Path: a result reaches the output through the input register, then the
//   result register; a stalled output can hold a transaction in the input
//   register before it moves on.
//   Throughput: one transaction per cycle unless the output stalls; the state
//   update is a single short logic step between input and state registers.
//   Stall: while the receiver holds i_out_ready low, the result register
//   holds and one more transaction may sit in the input register; then
//   o_in_ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous): both registers empty, mode idle,
//   status none, seen mask clear.
`timescale 1ns / 1ps

module gate_passage_sensor_tracker_core
    import gpst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      advance;

    // move the held transaction forward when the result slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    gpst_step u_step (
        .i_state (r_state),
        .i_item  (r_in_data),
        .o_state (n_state)
    );

    // update tracker state with each processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_data.status   <= n_state.status;
            r_out_data.mode_now <= n_state.mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/gpst_checker.sv =====
// Port-level checker for the gate passage sensor tracker, bound to the top
// level. Uses gpst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpst_checker
    import gpst_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // reset empties the result slot
    `GPST_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "result valid after reset")

    // an empty result slot never blocks the input side
    `GPST_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready,
        "input stalled with empty output")

    // a waiting input transaction holds
    `GPST_ASSERT(a_in_hold, i_clk, i_rst_n,
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data),
        "waiting input changed")

    // a stalled result holds
    `GPST_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data),
        "stalled result changed")

    // no status code beyond pass ok is ever reported
    `GPST_ASSERT(a_status_range, i_clk, i_rst_n,
        o_out_valid |-> (o_out_data.status <= ST_PASS_OK),
        "status code out of range")

endmodule

bind gate_passage_sensor_tracker_core gpst_checker u_gpst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/gpst_passage_checker.sv =====
// Checker for the gate passage sensor tracker: watches both channels, keeps its
// own copy of the tracker state and compares every result with its prediction.
// Depends on gpst_pkg for the payload types and the status and mode codes.
`timescale 1ns / 1ps

module gpst_passage_checker
    import gpst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_mismatches,
    output int        o_reports_due
);

    // predicted tracker state
    logic [1:0] task_run;
    logic       entered;
    logic       waiting_clear;
    logic [3:0] beams_seen;
    logic [2:0] status_now;
    logic [1:0] mode_shown;

    t_out_item gate_reports_due[$];

    initial begin
        o_mismatches  = 0;
        o_reports_due = 0;
    end

    task automatic note_mismatch(input string what);
        $display("[%0t] gpst mismatch: %s", $time, what);
        o_mismatches = o_mismatches + 1;
    endtask

    // Entrance and exit share one walk; only the mode code, wrong first mask and wrong status differ.
    task automatic walk_passage(input logic [3:0] beams, input logic [1:0] mode_code,
                                input logic [3:0] wrong_first,
                                input logic [2:0] wrong_status);
        if (!entered) begin
            entered       = 1'b1;
            waiting_clear = 1'b0;
            beams_seen    = NO_BEAMS;
            status_now    = ST_PASS_WAIT;
            mode_shown    = mode_code;
        end
        if (!waiting_clear) begin
            // latch the wrong-way alarm and freeze the mask
            if (beams_seen == wrong_first) begin
                status_now = wrong_status;
            end else begin
                beams_seen = beams_seen | beams;
                status_now = ST_PASS_WAIT;
            end
            if (beams_seen == FULL_MASK)
                waiting_clear = 1'b1;
        end else if (beams == NO_BEAMS) begin
            // all clear after a full mask: passage done, drop back to idle
            status_now = ST_PASS_OK;
            task_run   = MD_IDLE;
            entered    = 1'b0;
        end
    endtask

    // Advance the predicted state by one transaction and give its result.
    task automatic track_gate_tick(input t_in_item item, output t_out_item res);
        logic [3:0] beams;
        beams = ~item.sensor_levels;
        if (item.req_type == REQ_SET) begin
            mode_shown = item.new_mode;
            task_run   = item.new_mode;
            entered    = 1'b0;
        end else begin
            case (task_run)
                MD_ENTR: walk_passage(beams, MD_ENTR, OUT_ONLY, ST_ALARM_EXIT);
                MD_EXIT: walk_passage(beams, MD_EXIT, IN_ONLY, ST_ALARM_ENTR);
                MD_ALARM: begin
                    if (!entered) begin
                        entered       = 1'b1;
                        waiting_clear = 1'b0;
                        mode_shown    = MD_ALARM;
                    end
                    // classify the beams broken right now
                    if (beams == NO_BEAMS)
                        status_now = ST_NONE;
                    else if (beams[3] && beams[0])
                        status_now = ST_BOTH;
                    else if (beams[3])
                        status_now = ST_ALARM_EXIT;
                    else if (beams[0])
                        status_now = ST_ALARM_ENTR;
                    else
                        status_now = ST_ALARM_MID;
                end
                default: begin
                    if (!entered) begin
                        entered       = 1'b1;
                        waiting_clear = 1'b0;
                        mode_shown    = MD_IDLE;
                    end
                end
            endcase
        end
        res.status   = status_now;
        res.mode_now = mode_shown;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            task_run      = MD_IDLE;
            entered       = 1'b0;
            waiting_clear = 1'b0;
            beams_seen    = NO_BEAMS;
            status_now    = ST_NONE;
            mode_shown    = MD_IDLE;
            gate_reports_due.delete();
        end else begin
            // compare a taken result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (gate_reports_due.size() == 0) begin
                    note_mismatch($sformatf("result with nothing due: status %0d mode %0d",
                                            i_out_data.status, i_out_data.mode_now));
                end else begin
                    want = gate_reports_due.pop_front();
                    if (i_out_data.status !== want.status)
                        note_mismatch($sformatf("status got %0d want %0d",
                                                i_out_data.status, want.status));
                    if (i_out_data.mode_now !== want.mode_now)
                        note_mismatch($sformatf("mode_now got %0d want %0d",
                                                i_out_data.mode_now, want.mode_now));
                end
            end
            // predict the result of an accepted transaction
            if (i_in_valid && i_in_ready) begin
                track_gate_tick(i_in_data, want);
                gate_reports_due.push_back(want);
            end
        end
        o_reports_due = gate_reports_due.size();
    end

endmodule

// ===== bench/gate_passage_sensor_tracker_core_test.sv =====
// Testbench top for gate_passage_sensor_tracker_core: drives sensor ticks and
// mode commands with random gaps and output stalls, gives the verdict.
// Depends on gpst_pkg, the core and gpst_passage_checker.
`timescale 1ns / 1ps

module gate_passage_sensor_tracker_core_test;
    import gpst_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 600;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      gate_in_valid = 1'b0;
    logic      gate_in_ready;
    t_in_item  gate_in_data = '0;
    logic      gate_out_valid;
    logic      gate_out_ready = 1'b0;
    t_out_item gate_out_data;

    int mismatches;
    int reports_due;
    int items_sent = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int rx_left = 0;
    int rx_style = 0;

    gate_passage_sensor_tracker_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (gate_in_valid),
        .o_in_ready  (gate_in_ready),
        .i_in_data   (gate_in_data),
        .o_out_valid (gate_out_valid),
        .i_out_ready (gate_out_ready),
        .o_out_data  (gate_out_data)
    );

    gpst_passage_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (gate_in_valid),
        .i_in_ready    (gate_in_ready),
        .i_in_data     (gate_in_data),
        .i_out_valid   (gate_out_valid),
        .i_out_ready   (gate_out_ready),
        .i_out_data    (gate_out_data),
        .o_mismatches  (mismatches),
        .o_reports_due (reports_due)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Stall the receiver: switch between always ready, coin flip and long stalls.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 2);
            rx_left  <= $urandom_range(8, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: gate_out_ready <= 1'b1;
            1: gate_out_ready <= 1'($urandom_range(0, 1));
            default: gate_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // End the run when nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (gate_in_valid && gate_in_ready) || (gate_out_valid && gate_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gate_passage_sensor_tracker_core_test: done, errors");
            $finish;
        end
    end

    // Offer one transaction, in bursts separated by random gaps.
    task automatic offer_transaction(input logic req, input logic [3:0] levels,
                                     input logic [1:0] mode);
        int   gap;
        logic took;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                gate_in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        gate_in_valid <= 1'b1;
        gate_in_data  <= '{req_type: req, sensor_levels: levels, new_mode: mode};
        // sample ready away from the edge, then let the edge take it
        do begin
            @(negedge clk);
            took = gate_in_ready;
            @(posedge clk);
        end while (!took);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    // Sensor tick given as broken beams; the line levels are active low.
    task automatic offer_beams(input logic [3:0] beams);
        offer_transaction(REQ_TICK, ~beams, 2'($urandom));
    endtask

    task automatic offer_mode(input logic [1:0] mode);
        offer_transaction(REQ_SET, 4'($urandom), mode);
    endtask

    // Walk one person through the gate, inward or outward, with some jitter.
    task automatic walk_person(input logic inward);
        logic [3:0] path [6];
        logic [3:0] beams;
        int         reps;
        path = '{4'b0001, 4'b0011, 4'b0110, 4'b1100, 4'b1000, 4'b0000};
        foreach (path[k]) begin
            reps = $urandom_range(1, 3);
            repeat (reps) begin
                beams = inward ? path[k] : {path[k][0], path[k][1], path[k][2], path[k][3]};
                if ($urandom_range(0, 7) == 0)
                    beams = beams | 4'($urandom);
                offer_beams(beams);
            end
        end
    endtask

    initial begin
        int         pick;
        logic [1:0] walk_mode;
        logic       inward;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // idle tick out of reset
        offer_beams(4'b0000);
        // alarm: clear, both ends, out only, in only, mid only, everything
        offer_mode(MD_ALARM);
        offer_beams(4'b0000);
        offer_beams(4'b1001);
        offer_beams(4'b1000);
        offer_beams(4'b0001);
        offer_beams(4'b0110);
        offer_beams(4'b1111);
        // entrance entered from the out side: latch alarm exit
        offer_mode(MD_ENTR);
        offer_beams(4'b1000);
        offer_beams(4'b1111);
        offer_beams(4'b0011);
        // exit entered from the in side: latch alarm entrance
        offer_mode(MD_EXIT);
        offer_beams(4'b0001);
        offer_beams(4'b1111);
        // clean entrance: full mask, wait while blocked, pass, then idle
        offer_mode(MD_ENTR);
        offer_beams(4'b0001);
        offer_beams(4'b1111);
        offer_beams(4'b1111);
        offer_beams(4'b0000);
        offer_beams(4'b0000);
        // explicit idle
        offer_mode(MD_IDLE);
        offer_beams(4'b0000);

        // random part: mostly well-formed passages, then alarm, broken runs, noise
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                walk_mode = ($urandom_range(0, 1) == 0) ? MD_ENTR : MD_EXIT;
                inward = (walk_mode == MD_ENTR);
                if ($urandom_range(0, 3) == 0)
                    inward = !inward;
                offer_mode(walk_mode);
                walk_person(inward);
                repeat ($urandom_range(0, 2)) offer_beams(4'b0000);
            end else if (pick < 15) begin
                offer_mode(MD_ALARM);
                repeat ($urandom_range(2, 8)) offer_beams(4'($urandom));
            end else if (pick < 18) begin
                offer_mode(2'($urandom));
                repeat ($urandom_range(1, 10)) offer_beams(4'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    offer_transaction(1'($urandom), 4'($urandom), 2'($urandom));
            end
        end
        gate_in_valid <= 1'b0;

        // drain, then give stray results time to show up
        do @(negedge clk); while (reports_due != 0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("gate_passage_sensor_tracker_core_test: done, clean");
        else
            $display("gate_passage_sensor_tracker_core_test: done, errors");
        $finish;
    end

endmodule
